// ----- rtl/core/iida_pkg.sv -----
// Package with the transaction types, codes and cell commands of the indexed insert/delete array.
package iida_pkg;

    localparam logic [2:0] ACT_READ     = 3'd0;
    localparam logic [2:0] ACT_WRITE    = 3'd1;
    localparam logic [2:0] ACT_APPEND   = 3'd2;
    localparam logic [2:0] ACT_INSERT   = 3'd3;
    localparam logic [2:0] ACT_REMOVE   = 3'd4;
    localparam logic [2:0] ACT_POP_AT   = 3'd5;
    localparam logic [2:0] ACT_POP_LAST = 3'd6;
    localparam logic [2:0] ACT_UNUSED   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic signed [31:0] NOT_OK_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [2:0]         status;
        logic [6:0]         count;
    } t_out_item;

    typedef enum logic [2:0] {
        C_HOLD,
        C_WRITE,
        C_INSERT,
        C_CLOSE,
        C_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- rtl/core/iida_cell.sv -----
// One storage cell of the array chain, holding the element at a fixed position.
module iida_cell #(
    parameter int CW  = 7,
    parameter int POS = 0
) (
    input  logic               i_clk,
    input  iida_pkg::t_cell_cmd i_cmd,
    input  logic [CW-1:0]      i_pos,
    input  logic [CW-1:0]      i_count,
    input  logic signed [31:0] i_prev_data,
    input  logic signed [31:0] i_next_data,
    input  logic               i_found,
    input  logic signed [31:0] i_rd,
    output logic signed [31:0] o_data,
    output logic               o_found,
    output logic signed [31:0] o_rd
);

    localparam logic [CW-1:0] MY_POS = CW'(POS);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               hit;
    logic               above;
    logic               match;

    assign hit     = (MY_POS == i_pos);
    assign above   = (MY_POS > i_pos);
    assign match   = (r_data == i_cmd.value) && (MY_POS < i_count);
    assign o_found = i_found | match;
    assign o_rd    = i_rd | (hit ? r_data : 32'sd0);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            iida_pkg::C_HOLD: begin
                n_data = r_data;
            end
            iida_pkg::C_WRITE: begin
                if (hit) begin
                    n_data = i_cmd.value;
                end
            end
            iida_pkg::C_INSERT: begin
                if (hit) begin
                    n_data = i_cmd.value;
                end else if (above) begin
                    n_data = i_prev_data;
                end
            end
            iida_pkg::C_CLOSE: begin
                if (hit || above) begin
                    n_data = i_next_data;
                end
            end
            iida_pkg::C_REMOVE: begin
                if (o_found) begin
                    n_data = i_next_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ----- rtl/core/indexed_insert_delete_array.sv -----
// Top level of the indexed insert/delete array built as a chain of storage cells.
//
// Usage: a request transaction (action, index, value on i_req) is accepted at a
// rising edge where start is high and busy is low. Busy is high for the one
// cycle in which the cell chain executes the request. In the cycle after that,
// o_valid is high for exactly one cycle with o_result (read value, status and
// element count afterwards); the receiver cannot stall it.
// The result strobe follows acceptance after the execute state, and a new request
// may be accepted in the cycle the result is shown, so the block takes a new
// request only once the last one has executed. In the execute state, every
// cell compares, reads and shifts against its neighbors at once.
// Each cell holds one element; elements at and above the count are undefined.
// A synchronous active-low reset empties the array, clears busy and the strobe.
module indexed_insert_delete_array #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  iida_pkg::t_in_item i_req,
    output logic               o_valid,
    output iida_pkg::t_out_item o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    iida_pkg::t_state    r_state;
    iida_pkg::t_state    n_state;
    iida_pkg::t_in_item  r_req;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_valid;
    iida_pkg::t_out_item r_result;
    iida_pkg::t_out_item n_result;

    iida_pkg::t_cell_cmd cmd;
    logic [CW-1:0]       pos;
    logic [2:0]          status;
    logic                use_rd;
    logic                accept;
    logic                exec;
    logic [WW-1:0]       idx_w;
    logic [WW-1:0]       cnt_w;
    logic [WW-1:0]       cnt_next_w;
    logic                full;
    logic                empty;

    logic signed [31:0]  data_w  [CAPACITY];
    logic                found_w [CAPACITY+1];
    logic signed [31:0]  rd_w    [CAPACITY+1];

    assign found_w[0] = 1'b0;
    assign rd_w[0]    = 32'sd0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] prev_data;
        logic signed [31:0] next_data;
        if (g == 0) begin : g_first
            assign prev_data = 32'sd0;
        end else begin : g_mid_lo
            assign prev_data = data_w[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_data = 32'sd0;
        end else begin : g_mid_hi
            assign next_data = data_w[g+1];
        end
        iida_cell #(
            .CW  (CW),
            .POS (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_pos       (pos),
            .i_count     (r_count),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .i_found     (found_w[g]),
            .i_rd        (rd_w[g]),
            .o_data      (data_w[g]),
            .o_found     (found_w[g+1]),
            .o_rd        (rd_w[g+1])
        );
    end

    assign accept = start && !busy;
    assign idx_w  = WW'(r_req.index);
    assign cnt_w  = WW'(r_count);
    assign full   = (r_count == CAP_CNT);
    assign empty  = (r_count == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iida_pkg::S_IDLE: begin
                if (start) begin
                    n_state = iida_pkg::S_EXEC;
                end
            end
            iida_pkg::S_EXEC: begin
                n_state = iida_pkg::S_IDLE;
            end
            default: begin
                n_state = iida_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy = (r_state == iida_pkg::S_EXEC);
        exec = (r_state == iida_pkg::S_EXEC);
    end

    always_comb begin
        cmd.op    = iida_pkg::C_HOLD;
        cmd.value = r_req.value;
        pos       = CW'(idx_w);
        status    = iida_pkg::ST_OK;
        use_rd    = 1'b0;
        n_count   = r_count;
        if (exec) begin
            unique case (r_req.action)
                iida_pkg::ACT_READ: begin
                    if (idx_w >= cnt_w) begin
                        status = iida_pkg::ST_RANGE;
                    end else begin
                        use_rd = 1'b1;
                    end
                end
                iida_pkg::ACT_WRITE: begin
                    if (idx_w >= cnt_w) begin
                        status = iida_pkg::ST_RANGE;
                    end else begin
                        cmd.op = iida_pkg::C_WRITE;
                    end
                end
                iida_pkg::ACT_APPEND: begin
                    pos = r_count;
                    if (full) begin
                        status = iida_pkg::ST_FULL;
                    end else begin
                        cmd.op  = iida_pkg::C_WRITE;
                        n_count = r_count + 1'b1;
                    end
                end
                iida_pkg::ACT_INSERT: begin
                    if (idx_w > cnt_w) begin
                        status = iida_pkg::ST_RANGE;
                    end else if (full) begin
                        status = iida_pkg::ST_FULL;
                    end else begin
                        cmd.op  = iida_pkg::C_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                iida_pkg::ACT_REMOVE: begin
                    if (empty) begin
                        status = iida_pkg::ST_EMPTY;
                    end else begin
                        cmd.op = iida_pkg::C_REMOVE;
                        if (found_w[CAPACITY]) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            status = iida_pkg::ST_NOTFOUND;
                        end
                    end
                end
                iida_pkg::ACT_POP_AT: begin
                    if (empty) begin
                        status = iida_pkg::ST_EMPTY;
                    end else if (idx_w >= cnt_w) begin
                        status = iida_pkg::ST_RANGE;
                    end else begin
                        cmd.op  = iida_pkg::C_CLOSE;
                        use_rd  = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                iida_pkg::ACT_POP_LAST: begin
                    pos = r_count - 1'b1;
                    if (empty) begin
                        status = iida_pkg::ST_EMPTY;
                    end else begin
                        use_rd  = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    status = iida_pkg::ST_OK;
                end
            endcase
        end
    end

    assign cnt_next_w = WW'(n_count);

    always_comb begin
        n_result.status = status;
        n_result.count  = cnt_next_w[6:0];
        if (status != iida_pkg::ST_OK) begin
            n_result.read_value = iida_pkg::NOT_OK_VALUE;
        end else if (use_rd) begin
            n_result.read_value = rd_w[CAPACITY];
        end else begin
            n_result.read_value = 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iida_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (exec) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/iida_checker.sv -----
// Port-level checker for the indexed insert/delete array and its bind statement.
module iida_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input iida_pkg::t_out_item o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("Accepted transaction did not make the block busy.");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("Result strobe missing two cycles after acceptance.");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("Result strobe without a preceding execute cycle.");

    a_not_ok_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != iida_pkg::ST_OK))
            |-> (o_result.read_value == iida_pkg::NOT_OK_VALUE))
        else $error("Failed transaction returned a value other than minus one.");

endmodule

bind indexed_insert_delete_array iida_checker u_iida_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
